// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, disabled under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFTC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RFTC_ASSERT(lbl, prop, msg)
`define RFTC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- design/rftc_pkg.sv -----
// ---------------------------------------------------------------------------
// rftc_pkg
// Shared widths, register indexes and types of the film tone curve.
// ---------------------------------------------------------------------------
package rftc_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 18;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int FIELD_W   = 16;
    localparam int CURVE_W   = 17;
    localparam int MANT_W    = 31;
    localparam int CHAN_LAT  = 17;
    localparam int CON_LAT   = 4;

    localparam logic [CURVE_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic signed [15:0] LOG2E_Q14 = 16'sd23637;
    localparam logic [18:0] AVG_RECIP = 19'd349526;
    localparam int AVG_SHIFT = 20;
    localparam logic signed [21:0] OUT_MAX = 22'sd131071;
    localparam logic signed [21:0] OUT_MIN = -22'sd131072;

    localparam logic [CFG_IDX_W-1:0] REG_RED_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_EV  = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0]   low;
        logic [CFG_W-1:0]   high;
        logic [FIELD_W-1:0] strength;
        logic [FIELD_W-1:0] gev;
    } chan_cfg_t;

endpackage

// ----- design/rftc_pix_in_if.sv -----
// ---------------------------------------------------------------------------
// rftc_pix_in_if
// Input pixel channel: valid/ready handshake with linear RGB payload.
// ---------------------------------------------------------------------------
interface rftc_pix_in_if;
    import rftc_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] red_in;
    logic [IN_W-1:0] green_in;
    logic [IN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// ----- design/rftc_pix_out_if.sv -----
// ---------------------------------------------------------------------------
// rftc_pix_out_if
// Output pixel channel: valid/ready handshake with toned RGB payload.
// ---------------------------------------------------------------------------
interface rftc_pix_out_if;
    import rftc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] red_out;
    logic signed [OUT_W-1:0] green_out;
    logic signed [OUT_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ----- design/rftc_chan.sv -----
// ---------------------------------------------------------------------------
// rftc_chan
// One color channel: exposure, pipelined ratio divider and three-piece curve.
// ---------------------------------------------------------------------------
module rftc_chan #(
    parameter int SAMPLE_BITS     = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [rftc_pkg::IN_W-1:0]    x_in,
    input  rftc_pkg::chan_cfg_t          cfg,
    output logic [rftc_pkg::CURVE_W-1:0] c_out
);
    import rftc_pkg::*;

    localparam int XW  = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int IW  = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int PW  = XW + MANT_W;
    localparam int QW  = 17;
    localparam int SPS = 4;
    localparam int NDS = (QW + SPS - 1) / SPS;

    localparam logic [1:0] RGN_TOE      = 2'd0;
    localparam logic [1:0] RGN_LINEAR   = 2'd1;
    localparam logic [1:0] RGN_SHOULDER = 2'd2;

    function automatic logic [MANT_W-1:0] rom_entry(input int k);
        logic [63:0] xv;
        logic [63:0] yv;
        logic [63:0] term;
        logic [63:0] sum;
        xv = (64'(k) << 30) / EXP_TABLE_DEPTH;
        yv = (xv * LN2_Q30) >> 30;
        term = 64'd1 << 30;
        sum = term;
        for (int i = 1; i <= 20; i++)
        begin
            term = ((term * yv) >> 30) / 64'(i);
            sum = sum + term;
        end
        return sum[MANT_W-1:0];
    endfunction

    logic [MANT_W-1:0] rom [EXP_TABLE_DEPTH];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [MANT_W-1:0] ENTRY = rom_entry(g);
        assign rom[g] = ENTRY;
    end

    // configuration fields
    logic [15:0]        tp;
    logic [15:0]        sp;
    logic signed [20:0] ts;
    logic signed [20:0] tst;
    logic signed [15:0] ls_raw;
    logic signed [20:0] lof;
    logic signed [20:0] sl;
    logic signed [15:0] ss;

    assign tp     = cfg.low[31:16];
    assign ts     = $signed({cfg.low[47:32], 5'b0});
    assign tst    = $signed({cfg.low[63:48], 5'b0});
    assign sp     = cfg.high[15:0];
    assign ls_raw = $signed(cfg.high[31:16]);
    assign lof    = $signed({cfg.high[47:32], 5'b0});
    assign sl     = $signed({cfg.high[63:48], 5'b0});
    assign ss     = $signed(cfg.strength);

    // exposure
    logic signed [16:0] w_e;
    logic [IW+11:0]     idx_prod_e;
    logic [IW-1:0]      idx_e;

    assign w_e        = 17'($signed(cfg.gev)) + 17'($signed(cfg.low[15:0]));
    assign idx_prod_e = (IW+12)'(w_e[10:0]) * (IW+12)'(EXP_TABLE_DEPTH);
    assign idx_e      = idx_prod_e[IW+10:11];

    logic [XW-1:0]      x1_reg;
    logic [MANT_W-1:0]  m1_reg;
    logic signed [5:0]  n1_reg;
    logic [PW-1:0]      p2_reg;
    logic signed [5:0]  n2_reg;
    logic               nz2_reg;
    logic [CURVE_W-1:0] ex3_reg;
    logic [CURVE_W-1:0] ex3_next;
    logic signed [7:0]  sh3;
    logic [PW-1:0]      v3;

    always_comb
    begin
        sh3 = 8'(SAMPLE_BITS + 10) - 8'(n2_reg);
        v3  = p2_reg >> sh3[5:0];
        if (!nz2_reg)
            ex3_next = '0;
        else if (sh3 <= 8'sd0)
            ex3_next = ONE_Q16;
        else if (sh3 >= 8'sd64)
            ex3_next = '0;
        else if (v3 > PW'(ONE_Q16))
            ex3_next = ONE_Q16;
        else
            ex3_next = v3[CURVE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_in[XW-1:0];
            m1_reg  <= rom[idx_e];
            n1_reg  <= w_e[16:11];
            p2_reg  <= PW'(x1_reg) * PW'(m1_reg);
            n2_reg  <= n1_reg;
            nz2_reg <= |x1_reg;
            ex3_reg <= ex3_next;
        end
    end

    // region select and divider operands
    logic [QW-1:0]      a_sel;
    logic [QW-1:0]      d_sel;
    logic [1:0]         rgn_sel;
    logic signed [17:0] span;
    logic signed [33:0] lsp_prod;

    assign span     = $signed({2'b0, sp}) - $signed({2'b0, tp});
    assign lsp_prod = ls_raw * span;

    always_comb
    begin
        if (ex3_reg < {1'b0, tp})
        begin
            rgn_sel = RGN_TOE;
            a_sel   = ex3_reg;
            d_sel   = {1'b0, tp};
        end
        else if (ex3_reg < {1'b0, sp})
        begin
            rgn_sel = RGN_LINEAR;
            a_sel   = ex3_reg - {1'b0, tp};
            d_sel   = {1'b0, sp} - {1'b0, tp};
        end
        else
        begin
            rgn_sel = RGN_SHOULDER;
            a_sel   = ex3_reg - {1'b0, sp};
            d_sel   = ONE_Q16 - {1'b0, sp};
        end
    end

    logic [QW-1:0]      dv_rem_reg [NDS+1];
    logic [QW-1:0]      dv_q_reg   [NDS+1];
    logic [QW-1:0]      dv_d_reg   [NDS+1];
    logic [1:0]         dv_rgn_reg [NDS+1];
    logic signed [22:0] dv_lsp_reg [NDS+1];
    logic [QW-1:0]      dv_rem_next [NDS];
    logic [QW-1:0]      dv_q_next   [NDS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0] <= a_sel;
            dv_q_reg[0]   <= '0;
            dv_d_reg[0]   <= d_sel;
            dv_rgn_reg[0] <= rgn_sel;
            dv_lsp_reg[0] <= lsp_prod[33:11];
        end
    end

    for (genvar s = 0; s < NDS; s++)
    begin : g_div
        always_comb
        begin : step
            logic [QW:0]   t;
            logic          qb;
            logic [QW-1:0] rem;
            logic [QW-1:0] q;
            rem = dv_rem_reg[s];
            q   = dv_q_reg[s];
            t   = '0;
            qb  = 1'b0;
            for (int j = 0; j < SPS; j++)
            begin
                if (s * SPS + j < QW)
                begin
                    t  = (s * SPS + j == 0) ? {1'b0, rem} : {rem, 1'b0};
                    qb = t >= {1'b0, dv_d_reg[s]};
                    if (qb)
                        t = t - {1'b0, dv_d_reg[s]};
                    rem = t[QW-1:0];
                    q   = {q[QW-2:0], qb};
                end
            end
            dv_rem_next[s] = rem;
            dv_q_next[s]   = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[s+1] <= dv_rem_next[s];
                dv_q_reg[s+1]   <= dv_q_next[s];
                dv_d_reg[s+1]   <= dv_d_reg[s];
                dv_rgn_reg[s+1] <= dv_rgn_reg[s];
                dv_lsp_reg[s+1] <= dv_lsp_reg[s];
            end
        end
    end

    // curve pieces
    logic [QW-1:0]      r_d;
    logic [33:0]        rsq_d;
    assign r_d   = dv_q_reg[NDS];
    assign rsq_d = 34'(r_d) * 34'(r_d);

    logic [QW-1:0]      r1_reg;
    logic [1:0]         rgn1_reg;
    logic signed [22:0] lsp1_reg;
    logic [17:0]        rr1_reg;
    logic signed [38:0] tr1_reg;
    logic signed [23:0] mlin1_reg;
    logic signed [33:0] rs1_reg;

    logic [1:0]         rgn2_reg;
    logic signed [22:0] lsp2_reg;
    logic signed [38:0] tr2_reg;
    logic signed [39:0] tt2_reg;
    logic signed [41:0] lp2_reg;
    logic signed [50:0] wp2_reg;

    logic [1:0]         rgn3_reg;
    logic signed [22:0] lsp3_reg;
    logic signed [26:0] ypre3_reg;
    logic signed [20:0] w3_reg;

    logic [1:0]         rgn4_reg;
    logic signed [24:0] ybase4_reg;
    logic signed [26:0] ypre4_reg;
    logic [MANT_W-1:0]  mm4_reg;
    logic signed [9:0]  k4_reg;

    logic [1:0]         rgn5_reg;
    logic signed [24:0] ybase5_reg;
    logic signed [26:0] ypre5_reg;
    logic signed [41:0] dd5_reg;

    logic [1:0]         rgn6_reg;
    logic signed [24:0] ybase6_reg;
    logic signed [26:0] ypre6_reg;
    logic signed [42:0] pl6_reg;
    logic signed [41:0] ph6_reg;

    logic signed [48:0] y7_reg;
    logic [CURVE_W-1:0] c8_reg;

    logic signed [34:0] nrs;
    logic signed [21:0] base_tt;
    logic signed [40:0] toe_sum;
    logic signed [26:0] ytoe;
    logic signed [26:0] ylin;
    logic [IW+11:0]     idx_prod_s;
    logic [IW-1:0]      idx_s;
    logic [63:0]        e30;
    logic [9:0]         nk;
    logic [63:0]        e16;
    logic signed [63:0] ssum;
    logic signed [48:0] ysh;

    always_comb
    begin
        nrs        = -35'(rs1_reg);
        base_tt    = 22'(ts) + 22'(tst);
        toe_sum    = 41'(tt2_reg) + 41'(tr2_reg);
        ytoe       = 27'($signed(toe_sum[40:16]));
        ylin       = 27'(base_tt) + 27'($signed(lp2_reg[41:16]));
        idx_prod_s = (IW+12)'(w3_reg[10:0]) * (IW+12)'(EXP_TABLE_DEPTH);
        idx_s      = idx_prod_s[IW+10:11];
        nk         = 10'(-k4_reg);
        if (!k4_reg[9])
            e30 = 64'(mm4_reg) << k4_reg;
        else if (nk >= 10'd63)
            e30 = '0;
        else
            e30 = 64'(mm4_reg) >> nk;
        e16  = e30 >> 14;
        ssum = (64'(ph6_reg) <<< 21) + 64'(pl6_reg);
        ysh  = 49'(ybase6_reg) + 49'($signed(ssum[63:16]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg    <= r_d;
            rgn1_reg  <= dv_rgn_reg[NDS];
            lsp1_reg  <= dv_lsp_reg[NDS];
            rr1_reg   <= rsq_d[33:16];
            tr1_reg   <= tst * $signed({1'b0, r_d});
            mlin1_reg <= 24'(dv_lsp_reg[NDS]) + 24'(lof);
            rs1_reg   <= ss * $signed({1'b0, r_d});

            rgn2_reg  <= rgn1_reg;
            lsp2_reg  <= lsp1_reg;
            tr2_reg   <= tr1_reg;
            tt2_reg   <= ts * $signed({1'b0, rr1_reg});
            lp2_reg   <= $signed({1'b0, r1_reg}) * mlin1_reg;
            wp2_reg   <= nrs * LOG2E_Q14;

            rgn3_reg  <= rgn2_reg;
            lsp3_reg  <= lsp2_reg;
            ypre3_reg <= (rgn2_reg == RGN_TOE) ? ytoe : ylin;
            w3_reg    <= wp2_reg[50:30];

            rgn4_reg   <= rgn3_reg;
            ybase4_reg <= 25'(base_tt) + 25'(lsp3_reg);
            ypre4_reg  <= ypre3_reg;
            mm4_reg    <= rom[idx_s];
            k4_reg     <= w3_reg[20:11];

            rgn5_reg   <= rgn4_reg;
            ybase5_reg <= ybase4_reg;
            ypre5_reg  <= ypre4_reg;
            dd5_reg    <= $signed(42'(ONE_Q16) - e16[41:0]);

            rgn6_reg   <= rgn5_reg;
            ybase6_reg <= ybase5_reg;
            ypre6_reg  <= ypre5_reg;
            pl6_reg    <= sl * $signed({1'b0, dd5_reg[20:0]});
            ph6_reg    <= sl * $signed(dd5_reg[41:21]);

            y7_reg <= (rgn6_reg == RGN_SHOULDER) ? ysh : 49'(ypre6_reg);

            if (y7_reg < 49'sd0)
                c8_reg <= '0;
            else if (y7_reg > 49'sd65536)
                c8_reg <= ONE_Q16;
            else
                c8_reg <= y7_reg[CURVE_W-1:0];
        end
    end

    assign c_out = c8_reg;

endmodule

// ----- design/rgb_film_tone_curve.sv -----
// ---------------------------------------------------------------------------
// rgb_film_tone_curve
// Film-like tone mapping of linear RGB pixels, one per clock unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   pix_in carries one linear RGB pixel per transaction, pix_out one toned
//   pixel. Both use valid/ready; a transaction completes when both are high.
//   Configuration goes through cfg_we/cfg_index/cfg_wdata, one register per
//   cycle; users must write only while no pixel is in flight (not enforced).
// Pipeline: 17 per-channel curve stages, including a 5-stage ratio
//   divider, then 4 contrast stages, from an input transaction to the
//   result on pix_out.
// Throughput: one pixel per clock; the pipeline takes a new pixel every
//   cycle in which pix_out is not stalled.
// Reset: clears all configuration registers to zero and empties the
//   pipeline.
// Stall: while pix_out.valid is high and pix_out.ready low, the whole
//   pipeline holds and pix_in.ready is low; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_film_tone_curve #(
    parameter int SAMPLE_BITS     = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rftc_pix_in_if.sink                    pix_in,
    rftc_pix_out_if.source                 pix_out,
    input  logic                           cfg_we,
    input  logic [rftc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rftc_pkg::CFG_W-1:0]     cfg_wdata
);
    import rftc_pkg::*;

    localparam int TOTAL_LAT = CHAN_LAT + CON_LAT;

    logic [CFG_W-1:0]   low_reg  [3];
    logic [CFG_W-1:0]   high_reg [3];
    logic [CFG_W-1:0]   strength_reg;
    logic [FIELD_W-1:0] gev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
            strength_reg <= '0;
            gev_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_LOW:    low_reg[0]   <= cfg_wdata;
                REG_RED_HIGH:   high_reg[0]  <= cfg_wdata;
                REG_GREEN_LOW:  low_reg[1]   <= cfg_wdata;
                REG_GREEN_HIGH: high_reg[1]  <= cfg_wdata;
                REG_BLUE_LOW:   low_reg[2]   <= cfg_wdata;
                REG_BLUE_HIGH:  high_reg[2]  <= cfg_wdata;
                REG_STRENGTH:   strength_reg <= cfg_wdata;
                REG_GLOBAL_EV:  gev_reg      <= cfg_wdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                 en;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    assign en       = !vld_reg[TOTAL_LAT-1] || pix_out.ready;
    assign vld_next = {vld_reg[TOTAL_LAT-2:0], pix_in.valid};
    assign pix_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // channels
    logic [IN_W-1:0]    x_in [3];
    chan_cfg_t          ccfg [3];
    logic [CURVE_W-1:0] c_ch [3];

    assign x_in[0] = pix_in.red_in;
    assign x_in[1] = pix_in.green_in;
    assign x_in[2] = pix_in.blue_in;

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        assign ccfg[ch].low      = low_reg[ch];
        assign ccfg[ch].high     = high_reg[ch];
        assign ccfg[ch].strength = strength_reg[ch*FIELD_W +: FIELD_W];
        assign ccfg[ch].gev      = gev_reg;

        rftc_chan #(
            .SAMPLE_BITS     (SAMPLE_BITS),
            .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
        ) u_chan (
            .clk   (clk),
            .en    (en),
            .x_in  (x_in[ch]),
            .cfg   (ccfg[ch]),
            .c_out (c_ch[ch])
        );
    end

    // contrast around the channel mean
    logic [FIELD_W-1:0] kc;
    assign kc = strength_reg[CFG_W-1 -: FIELD_W];

    logic [18:0]             sum1_reg;
    logic [CURVE_W-1:0]      c1_reg [3];
    logic [CURVE_W-1:0]      avg2_reg;
    logic [CURVE_W-1:0]      c2_reg [3];
    logic signed [34:0]      prod3_reg [3];
    logic [28:0]             base3_reg;
    logic signed [OUT_W-1:0] out4_reg [3];

    logic [37:0]        avg_prod;
    logic signed [17:0] diff [3];
    logic signed [35:0] vsum [3];
    logic signed [21:0] vsh  [3];

    always_comb
    begin
        avg_prod = 38'(sum1_reg) * 38'(AVG_RECIP);
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = $signed({1'b0, c2_reg[i]}) - $signed({1'b0, avg2_reg});
            vsum[i] = 36'(prod3_reg[i]) + 36'($signed({1'b0, base3_reg}));
            vsh[i]  = vsum[i][35:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum1_reg  <= 19'(c_ch[0]) + 19'(c_ch[1]) + 19'(c_ch[2]);
            avg2_reg  <= avg_prod[AVG_SHIFT +: CURVE_W];
            base3_reg <= {avg2_reg, 12'b0};
            for (int i = 0; i < 3; i++)
            begin
                c1_reg[i]    <= c_ch[i];
                c2_reg[i]    <= c1_reg[i];
                prod3_reg[i] <= diff[i] * $signed({1'b0, kc});
                if (vsh[i] > OUT_MAX)
                    out4_reg[i] <= OUT_MAX[OUT_W-1:0];
                else if (vsh[i] < OUT_MIN)
                    out4_reg[i] <= OUT_MIN[OUT_W-1:0];
                else
                    out4_reg[i] <= vsh[i][OUT_W-1:0];
            end
        end
    end

    assign pix_out.valid     = vld_reg[TOTAL_LAT-1];
    assign pix_out.red_out   = out4_reg[0];
    assign pix_out.green_out = out4_reg[1];
    assign pix_out.blue_out  = out4_reg[2];

    `RFTC_ASSERT(a_stall_holds_pipe, !en |=> $stable(vld_reg), "pipeline moved during stall")
    `RFTC_ASSERT(a_accept_enters, (pix_in.valid && pix_in.ready) |=> vld_reg[0], "transaction lost at entry")
    `RFTC_ASSERT_NEVER(a_no_accept_when_blocked, pix_out.valid && !pix_out.ready && pix_in.ready, "input taken while output blocked")

endmodule

// ----- bench/tb_rgb_film_tone_curve.sv -----
// ---------------------------------------------------------------------------
// tb_rgb_film_tone_curve
// Self-checking bench for the film tone curve: a bit-exact fixed-point
// predictor computes each toned pixel, and a checker compares every output
// transaction in order. Curves are reprogrammed between phases while idle.
// ---------------------------------------------------------------------------
module tb_rgb_film_tone_curve;
    import rftc_pkg::*;

    localparam int SBITS = 16;
    localparam int DEPTH = 256;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [OUT_W-1:0] r;
        logic signed [OUT_W-1:0] g;
        logic signed [OUT_W-1:0] b;
    } tone_px_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    rftc_pix_in_if pix_in ();
    rftc_pix_out_if pix_out ();

    rgb_film_tone_curve dut (
        .clk(clk), .rst_n(rst_n), .pix_in(pix_in.sink), .pix_out(pix_out.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    logic [63:0] curve_regs [0:6];
    logic [15:0] gev_reg;
    logic [63:0] mant_rom [0:DEPTH-1];
    tone_px_t expected_px [$];
    int mismatches;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit timed_out;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic longint fshr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint sx16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] build_mant(int k);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        x = (64'(k) << 30) / DEPTH;
        y = (x * LN2_Q30) >> 30;
        term = 64'd1 << 30;
        sum = term;
        for (int i = 1; i <= 20; i++)
        begin
            term = ((term * y) >> 30) / i;
            sum += term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] mant_of(longint w, output longint n);
        longint e;
        longint f;
        longint idx;
        e = fshr(w, 11);
        f = w - e * 2048;
        idx = (f * DEPTH) >>> 11;
        if (idx >= DEPTH)
            idx = DEPTH - 1;
        n = e;
        return mant_rom[idx];
    endfunction

    function automatic longint tone_channel(logic [15:0] sample, logic [63:0] lo,
                                            logic [63:0] hi, longint ss);
        longint x, n, ex, y, tp, ts, tst, sp, ls, lof, sl, sh, r, span, w, k;
        longint e30, e16;
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] mm;
        x = sample;
        m = mant_of(sx16(gev_reg) + sx16(lo[15:0]), n);
        tp = lo[31:16];
        ts = sx16(lo[47:32]) * 32;
        tst = sx16(lo[63:48]) * 32;
        sp = hi[15:0];
        ls = sx16(hi[31:16]) * 32;
        lof = sx16(hi[47:32]) * 32;
        sl = sx16(hi[63:48]) * 32;
        if (x == 0)
            ex = 0;
        else
        begin
            sh = SBITS + 10 - n;
            if (sh <= 0)
                ex = 65536;
            else if (sh >= 64)
                ex = 0;
            else
            begin
                v = (64'(x) * m) >> sh;
                ex = (v > 64'd65536) ? 65536 : longint'(v);
            end
        end
        if (ex < tp)
        begin
            r = (ex <<< 16) / tp;
            y = fshr(ts * ((r * r) >>> 16) + tst * r, 16);
        end
        else if (ex < sp)
        begin
            span = sp - tp;
            r = ((ex - tp) <<< 16) / span;
            y = ts + tst + fshr(r * (fshr(ls * span, 16) + lof), 16);
        end
        else
        begin
            r = ((ex - sp) <<< 16) / (65536 - sp);
            w = fshr(-(r * ss) * 23637, 30);
            mm = mant_of(w, k);
            if (k >= 0)
                e30 = longint'(mm << k);
            else if (-k >= 63)
                e30 = 0;
            else
                e30 = longint'(mm >> (-k));
            e16 = fshr(e30, 14);
            y = ts + tst + fshr(ls * (sp - tp), 16) + fshr(sl * (65536 - e16), 16);
        end
        if (y < 0)
            y = 0;
        if (y > 65536)
            y = 65536;
        return y;
    endfunction

    function automatic tone_px_t tone_pixel(logic [15:0] rin, logic [15:0] gin,
                                            logic [15:0] bin);
        longint c [3];
        longint avg, k, v;
        tone_px_t px;
        logic [17:0] o [3];
        c[0] = tone_channel(rin, curve_regs[0], curve_regs[1], sx16(curve_regs[6][15:0]));
        c[1] = tone_channel(gin, curve_regs[2], curve_regs[3], sx16(curve_regs[6][31:16]));
        c[2] = tone_channel(bin, curve_regs[4], curve_regs[5], sx16(curve_regs[6][47:32]));
        k = curve_regs[6][63:48];
        avg = (c[0] + c[1] + c[2]) / 3;
        for (int i = 0; i < 3; i++)
        begin
            v = fshr(avg * 4096 + (c[i] - avg) * k, 14);
            if (v > 131071)
                v = 131071;
            if (v < -131072)
                v = -131072;
            o[i] = v[17:0];
        end
        px.r = o[0];
        px.g = o[1];
        px.b = o[2];
        return px;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GLOBAL_EV)
            gev_reg = val[15:0];
        else
            curve_regs[idx] = val;
    endtask

    task automatic send_pixel(logic [15:0] rin, logic [15:0] gin, logic [15:0] bin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red_in <= rin;
        pix_in.green_in <= gin;
        pix_in.blue_in <= bin;
        do
            @(posedge clk);
        while (!pix_in.ready);
        expected_px.push_back(tone_pixel(rin, gin, bin));
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        pix_in.valid <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(4096));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_low();
        logic [15:0] off;
        logic [15:0] tp;
        off = 16'($signed($urandom_range(8192)) - 4096);
        tp = 16'($urandom_range(40000));
        return {16'($urandom_range(4096)), 16'($urandom_range(4096)), tp, off};
    endfunction

    function automatic logic [63:0] rand_high();
        return {16'($urandom_range(4096)), 16'($signed($urandom_range(2048)) - 1024),
                16'($urandom_range(3072)), 16'($urandom_range(20000, 65535))};
    endfunction

    task automatic program_random_curves();
        for (int i = 0; i < 6; i += 2)
        begin
            write_reg(3'(i), rand_low());
            write_reg(3'(i + 1), rand_high());
        end
        write_reg(REG_STRENGTH, {16'($urandom_range(8192)), 16'($urandom_range(8192)),
                                 16'($urandom_range(8192)), 16'($urandom_range(8192))});
        write_reg(REG_GLOBAL_EV, 64'(16'($signed($urandom_range(4096)) - 2048)));
    endtask

    task automatic test_reset_defaults();
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'h1000, 16'h0001);
        drain_pipe();
    endtask

    task automatic test_curve_regions();
        write_reg(REG_RED_LOW, {16'sd1024, 16'sd512, 16'd16384, 16'sd0});
        write_reg(REG_RED_HIGH, {16'sd1024, 16'sd256, 16'sd1536, 16'd49152});
        write_reg(REG_GREEN_LOW, {16'sd2048, 16'sd1024, 16'd0, 16'sd1024});
        write_reg(REG_GREEN_HIGH, {16'sd2048, 16'sd0, 16'sd2048, 16'd65535});
        write_reg(REG_BLUE_LOW, {16'sd512, 16'sd512, 16'd40000, -16'sd2048});
        write_reg(REG_BLUE_HIGH, {16'sd4096, 16'sd100, 16'sd200, 16'd30000});
        write_reg(REG_STRENGTH, {16'd8192, 16'sd4096, 16'sd2048, 16'sd1024});
        write_reg(REG_GLOBAL_EV, 64'd0);
        for (int s = 0; s < 8; s++)
            send_pixel(16'(s * 2048), 16'(16'hFFFF - s * 4096), 16'(s * 700 + 1));
        drain_pipe();
    endtask

    task automatic test_exposure_extremes();
        write_reg(REG_GLOBAL_EV, 64'h7FFF);
        send_pixel(16'h0001, 16'h0000, 16'hFFFF);
        drain_pipe();
        write_reg(REG_GLOBAL_EV, 64'h8000);
        send_pixel(16'hFFFF, 16'h8000, 16'h0001);
        drain_pipe();
        write_reg(REG_RED_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_RED_HIGH, 64'h8000_8000_8000_8000);
        write_reg(REG_STRENGTH, 64'hFFFF_8000_7FFF_FFFF);
        write_reg(REG_GLOBAL_EV, 64'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(16'h1000, 16'h0800, 16'hFFFF);
        drain_pipe();
        write_reg(REG_RED_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_RED_LOW, 64'h7FFF_7FFF_FFFF_7FFF);
        write_reg(REG_STRENGTH, 64'hFFFF_7FFF_7FFF_7FFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        drain_pipe();
    endtask

    task automatic test_random_pixels(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                drain_pipe();
                program_random_curves();
            end
            send_pixel(rand_sample(), rand_sample(), rand_sample());
        end
        drain_pipe();
    endtask

    task automatic test_random_registers(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
            begin
                drain_pipe();
                for (int j = 0; j < 7; j++)
                    write_reg(3'(j), {$urandom, $urandom});
                write_reg(REG_GLOBAL_EV, 64'($urandom));
            end
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
        end
        drain_pipe();
    endtask

    always @(posedge clk)
    begin
        tone_px_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_px.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel r=%0d g=%0d b=%0d",
                             pix_out.red_out, pix_out.green_out, pix_out.blue_out);
            end
            else
            begin
                want = expected_px.pop_front();
                if (want.r !== pix_out.red_out || want.g !== pix_out.green_out
                    || want.b !== pix_out.blue_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 want.r, want.g, want.b, pix_out.red_out,
                                 pix_out.green_out, pix_out.blue_out);
                end
            end
        end
    end

    always @(negedge clk)
        pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1;
            $display("tb_rgb_film_tone_curve NOT OK");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            mant_rom[i] = build_mant(i);
        for (int i = 0; i < 7; i++)
            curve_regs[i] = '0;
        gev_reg = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 0;
        send_idle_pct = 23;
        recv_idle_pct = 69;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        pix_in.valid = 0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_out.ready = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_reset_defaults();
        test_curve_regions();
        test_exposure_extremes();
        test_random_pixels(150);
        test_random_registers(50);
        send_idle_pct = 69;
        recv_idle_pct = 23;
        test_random_pixels(150);
        test_random_registers(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(150);
        test_random_registers(50);
        if (mismatches == 0)
            $display("tb_rgb_film_tone_curve OK");
        else
            $display("tb_rgb_film_tone_curve NOT OK");
        $finish;
    end
endmodule
